// ----- design/frt_pkg.sv -----
// Package for the fragment reassembly tracker: status codes, reset values,
// item, result and per-device state types. No dependencies.
package frt_pkg;

  localparam int unsigned DEVICE_COUNT_DEF = 16;
  localparam int unsigned BUFFER_BYTES_DEF = 2048;

  localparam logic [7:0] HEADER_RESET = 8'd24;
  localparam logic [7:0] START_INDEX  = 8'd2;
  localparam logic [7:0] FIRST_PIECE  = 8'd1;

  localparam logic [2:0] ST_PASS     = 3'd0;
  localparam logic [2:0] ST_SINGLE   = 3'd1;
  localparam logic [2:0] ST_STARTED  = 3'd2;
  localparam logic [2:0] ST_APPENDED = 3'd3;
  localparam logic [2:0] ST_TOO_LONG = 3'd4;
  localparam logic [2:0] ST_ORDER    = 3'd5;

  typedef struct packed {
    logic [3:0]  device;
    logic        wrapped;
    logic [7:0]  piece_index;
    logic [7:0]  piece_count;
    logic [11:0] item_bytes;
  } frt_item_t;

  typedef struct packed {
    logic        complete;
    logic [2:0]  status;
    logic        store_enable;
    logic [11:0] store_offset;
    logic        store_skips_header;
    logic [11:0] store_count;
    logic [11:0] total_length;
  } frt_result_t;

  // Per-device gather state; only meaningful while the device is busy
  typedef struct packed {
    logic [7:0]  exp_count;
    logic [7:0]  exp_index;
    logic [11:0] gathered;
  } frt_entry_t;

  // State write-back from the decision logic
  typedef struct packed {
    logic       wr;
    logic       busy;
    frt_entry_t entry;
  } frt_update_t;

endpackage

// ----- design/frt_if.sv -----
// Handshake interfaces of the fragment reassembly tracker: item input,
// result output and header-length configuration. Depends on frt_pkg.
interface frt_in_if
  import frt_pkg::*;
();
  logic        valid;
  logic        ready;
  logic [3:0]  device;
  logic        wrapped;
  logic [7:0]  piece_index;
  logic [7:0]  piece_count;
  logic [11:0] item_bytes;

  modport source (output valid, device, wrapped, piece_index, piece_count, item_bytes,
                  input ready);
  modport sink   (input valid, device, wrapped, piece_index, piece_count, item_bytes,
                  output ready);
endinterface

interface frt_out_if
  import frt_pkg::*;
();
  logic        valid;
  logic        ready;
  logic        complete;
  logic [2:0]  status;
  logic        store_enable;
  logic [11:0] store_offset;
  logic        store_skips_header;
  logic [11:0] store_count;
  logic [11:0] total_length;

  modport source (output valid, complete, status, store_enable, store_offset,
                  store_skips_header, store_count, total_length,
                  input ready);
  modport sink   (input valid, complete, status, store_enable, store_offset,
                  store_skips_header, store_count, total_length,
                  output ready);
endinterface

interface frt_cfg_if
  import frt_pkg::*;
();
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ----- design/frt_decide.sv -----
// Per-item decision logic: classifies one fragment against its device state
// and yields the result and the state write-back. Depends on frt_pkg.
module frt_decide
  import frt_pkg::*;
#(
  parameter int unsigned BUFFER_BYTES = BUFFER_BYTES_DEF
) (
  input  frt_item_t   item_i,
  input  logic        in_range_i,
  input  logic        busy_i,
  input  frt_entry_t  entry_i,
  input  logic [7:0]  header_i,
  output frt_result_t res_o,
  output frt_update_t upd_o
);

  logic [12:0] sum;
  logic [12:0] body;
  logic        append_bad;
  logic        is_last;

  assign sum        = {1'b0, entry_i.gathered} + {1'b0, item_i.item_bytes};
  assign body       = sum - {5'd0, header_i};
  assign append_bad = (sum < {5'd0, header_i}) || (body > 13'(BUFFER_BYTES));
  assign is_last    = (entry_i.exp_index == entry_i.exp_count);

  always_comb begin
    res_o       = '0;
    res_o.status = ST_ORDER;
    upd_o       = '0;
    upd_o.entry = entry_i;
    if (!item_i.wrapped) begin
      res_o.complete     = 1'b1;
      res_o.status       = ST_PASS;
      res_o.total_length = item_i.item_bytes;
    end else if (!in_range_i) begin
      res_o.status = ST_ORDER;
    end else if (!busy_i && item_i.piece_count == FIRST_PIECE) begin
      res_o.complete     = 1'b1;
      res_o.status       = ST_SINGLE;
      res_o.total_length = item_i.item_bytes;
    end else if (!busy_i && item_i.piece_index == FIRST_PIECE &&
                 item_i.piece_count > FIRST_PIECE) begin
      if (item_i.item_bytes > 12'(BUFFER_BYTES)) begin
        res_o.status = ST_TOO_LONG;
      end else begin
        res_o.status         = ST_STARTED;
        res_o.store_enable   = 1'b1;
        res_o.store_count    = item_i.item_bytes;
        upd_o.wr             = 1'b1;
        upd_o.busy           = 1'b1;
        upd_o.entry.exp_count = item_i.piece_count;
        upd_o.entry.exp_index = START_INDEX;
        upd_o.entry.gathered  = item_i.item_bytes;
      end
    end else if (busy_i && item_i.piece_index == entry_i.exp_index &&
                 item_i.piece_count == entry_i.exp_count) begin
      upd_o.wr = 1'b1;
      if (append_bad) begin
        res_o.status = ST_TOO_LONG;
      end else begin
        res_o.status             = ST_APPENDED;
        res_o.store_enable       = 1'b1;
        res_o.store_offset       = entry_i.gathered;
        res_o.store_skips_header = 1'b1;
        res_o.store_count        = (item_i.item_bytes >= {4'd0, header_i}) ?
                                   item_i.item_bytes - {4'd0, header_i} : 12'd0;
        if (is_last) begin
          res_o.complete     = 1'b1;
          res_o.total_length = body[11:0];
        end else begin
          upd_o.busy            = 1'b1;
          upd_o.entry.exp_index = entry_i.exp_index + 8'd1;
          upd_o.entry.gathered  = body[11:0];
        end
      end
    end else begin
      // Abort any gather in progress
      res_o.status = ST_ORDER;
      upd_o.wr     = 1'b1;
    end
  end

endmodule

// ----- design/fragment_reassembly_tracker_core.sv -----
// Top level of the fragment reassembly tracker: input stage, per-device state
// memory with busy flags, and result register. Depends on frt_pkg, frt_if, frt_decide.
//
//   port    | role   | transfer carries
//   --------+--------+--------------------------------------------------------
//   in_i    | sink   | device, wrapped, piece_index, piece_count, item_bytes
//   out_o   | source | complete, status, store_* fields, total_length
//   cfg_i   | sink   | data: header_bytes, always ready
//
// One item per cycle sustained while the result register is free or its result is taken;
// each item passes through the input stage and then the result register.
// The state read happens as the item is registered; the write-back lands
// as its result is registered, with a forward for the next item on the same device.
// Reset clears all busy flags at once (every device idle) and sets header_bytes
// to 24; no clearing pass. A stalled result holds the input stage, and input
// ready drops only while both stages are full.
module fragment_reassembly_tracker_core
  import frt_pkg::*;
#(
  parameter int unsigned DEVICE_COUNT = DEVICE_COUNT_DEF,
  parameter int unsigned BUFFER_BYTES = BUFFER_BYTES_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  frt_in_if.sink    in_i,
  frt_cfg_if.sink   cfg_i,
  frt_out_if.source out_o
);

  localparam int unsigned IDX_W = (DEVICE_COUNT > 1) ? $clog2(DEVICE_COUNT) : 1;

  // Configuration
  logic [7:0] header_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q <= HEADER_RESET;
    end else if (cfg_i.valid) begin
      header_q <= cfg_i.data;
    end
  end

  // Handshake control
  logic in_xfer;
  logic out_free;
  logic s1_valid_q;
  logic out_valid_q;
  logic s1_adv;

  assign out_free    = !out_valid_q || out_o.ready;
  assign in_i.ready  = !s1_valid_q || out_free;
  assign in_xfer     = in_i.valid && in_i.ready;
  assign s1_adv      = s1_valid_q && out_free;

  // Incoming item and its device index
  frt_item_t  item_in;
  logic [8:0] dev_wide;
  logic [IDX_W-1:0] idx_in;
  logic       in_range_in;

  assign item_in.device      = in_i.device;
  assign item_in.wrapped     = in_i.wrapped;
  assign item_in.piece_index = in_i.piece_index;
  assign item_in.piece_count = in_i.piece_count;
  assign item_in.item_bytes  = in_i.item_bytes;

  assign dev_wide    = {5'd0, in_i.device};
  assign idx_in      = dev_wide[IDX_W-1:0];
  assign in_range_in = dev_wide < 9'(DEVICE_COUNT);

  // Input stage
  frt_item_t        item_q;
  logic [IDX_W-1:0] idx_q;
  logic             in_range_q;
  logic             busy_q;
  frt_entry_t       entry_q;

  frt_result_t res;
  frt_update_t upd;
  logic        fwd;

  // Forward the write-back of the item leaving the stage to the one entering
  assign fwd = s1_adv && upd.wr && (idx_q == idx_in);

  // Per-device state: entries hold no reset, the busy flags qualify them
  frt_entry_t             state_mem [DEVICE_COUNT];
  logic [DEVICE_COUNT-1:0] busy_q_v;

  always_ff @(posedge clk_i) begin
    if (s1_adv && upd.wr) begin
      state_mem[idx_q] <= upd.entry;
    end
    if (in_xfer) begin
      item_q     <= item_in;
      idx_q      <= idx_in;
      in_range_q <= in_range_in;
      if (fwd) begin
        entry_q <= upd.entry;
        busy_q  <= upd.busy;
      end else begin
        entry_q <= state_mem[idx_in];
        busy_q  <= busy_q_v[idx_in];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q_v <= '0;
    end else if (s1_adv && upd.wr) begin
      busy_q_v[idx_q] <= upd.busy;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_xfer;
    end
  end

  frt_decide #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_decide (
    .item_i     (item_q),
    .in_range_i (in_range_q),
    .busy_i     (busy_q),
    .entry_i    (entry_q),
    .header_i   (header_q),
    .res_o      (res),
    .upd_o      (upd)
  );

  // Result register
  frt_result_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      res_q <= res;
    end
  end

  assign out_o.valid              = out_valid_q;
  assign out_o.complete           = res_q.complete;
  assign out_o.status             = res_q.status;
  assign out_o.store_enable       = res_q.store_enable;
  assign out_o.store_offset       = res_q.store_offset;
  assign out_o.store_skips_header = res_q.store_skips_header;
  assign out_o.store_count        = res_q.store_count;
  assign out_o.total_length       = res_q.total_length;

  // Checks
  a_ready_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (out_valid_q && !out_o.ready && s1_valid_q))
    else $error("input stalled without a stalled result");

  a_store_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.store_enable) |->
      (out_o.store_offset == 12'd0 && out_o.store_count == 12'd0 &&
       !out_o.store_skips_header))
    else $error("store fields set without store enable");

  a_total_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.complete) |-> (out_o.total_length == 12'd0))
    else $error("total length set on incomplete result");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_o.status <= ST_ORDER))
    else $error("status code out of range");

  a_started_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_o.status == ST_STARTED) |->
      (out_o.store_enable && !out_o.store_skips_header &&
       out_o.store_offset == 12'd0 && !out_o.complete))
    else $error("malformed started result");

endmodule
